// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL; clock and reset are clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/dmvs_pkg.sv =====
// Package: shared constants and register codes of the divergence stencil.
`default_nettype none

package dmvs_pkg;

  localparam int unsigned DEF_MAX_WIDTH   = 1024;
  localparam int unsigned DEF_SAMPLE_BITS = 24;

  localparam int unsigned ROW_W      = 12;
  localparam int unsigned MAX_ROWS   = 4096;
  localparam int unsigned IMG_W_BITS = 11;
  localparam int unsigned IMG_H_BITS = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = IMG_W_BITS'(1024);
  localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = IMG_H_BITS'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== src/divergence_mean_variance_stencil.sv =====
// Top level: raster-order divergence mean/variance stencil with line-buffer memories.
//
// Usage
//   s_axis carries one grid pixel per item in raster order: tdata holds mean_u,
//   var_u, mean_v, var_v. m_axis carries result items: tdata holds div_mean,
//   div_var, out_column, out_row; tlast marks the last result caused by one
//   input item, tuser[0] marks the result for the final pixel of the frame.
//   The cfg port writes image_width (index 0) or image_height (index 1); users write
//   only while idle (unchecked); a write restarts the frame at row 0, column 0.
// Timing
//   One pixel per cycle while m_axis keeps up. A result is offered from the
//   output slots once its pixel has passed the compute stage (fed by the
//   prefetch of the next column); it can be taken at the next edge.
//   Results lag one row; row 0 gives none. On the final row each pixel after
//   the first also yields a bottom-row result, and the last pixel one more, so the
//   output port (one result per cycle while m_axis_tready is high) sets the rate.
// Reset / stall
//   After reset and after each config write, s_axis_tready stays low while the
//   line-buffer read of column 0 is primed. Memories need no clearing.
//   When m_axis stalls, up to three results wait in the output slots and one
//   more pixel waits in the compute stage; then s_axis_tready drops.
`default_nettype none

module divergence_mean_variance_stencil #(
  parameter int unsigned MAX_WIDTH   = dmvs_pkg::DEF_MAX_WIDTH,
  parameter int unsigned SAMPLE_BITS = dmvs_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // config write port
  input  wire logic                               cfg_we_i,
  input  wire logic [dmvs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [dmvs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // pixel input
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: mean_u, var_u, mean_v, var_v (low to high)
  input  wire logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // result output
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata: div_mean, div_var, out_column, out_row (low to high), zero padded
  output logic [((2*SAMPLE_BITS+7+$clog2(MAX_WIDTH)+dmvs_pkg::ROW_W+7)/8)*8-1:0]
                                                  m_axis_tdata,
  output logic                                    m_axis_tlast,  // run_last
  // tuser: frame_last
  output logic [0:0]                              m_axis_tuser
);
  import dmvs_pkg::*;

  localparam int unsigned SB       = SAMPLE_BITS;
  localparam int unsigned CW       = $clog2(MAX_WIDTH);
  localparam int unsigned MW       = SB + 3;   // div_mean width
  localparam int unsigned VW       = SB + 4;   // div_var width
  localparam int unsigned PW       = 4 * SB;
  localparam int unsigned OUT_BITS = MW + VW + CW + ROW_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // last field in the lowest bits
  typedef struct packed {
    logic [SB-1:0] vv;
    logic [SB-1:0] mv;
    logic [SB-1:0] vu;
    logic [SB-1:0] mu;
  } pix_t;

  typedef struct packed {
    logic [SB-1:0] vu;
    logic [SB-1:0] mu;
  } upair_t;

  // compute stage contents
  typedef struct packed {
    pix_t             cur;
    pix_t             above;
    pix_t             left;
    pix_t             in1;    // current row, column - 1
    pix_t             in2;    // current row, column - 2
    upair_t           two;
    logic [CW-1:0]    col;
    logic [ROW_W-1:0] row;
    logic             first;
    logic             last;
    logic             col1;
    logic             r0;
    logic             r1;
    logic             rlast;
  } s1_t;

  typedef struct packed {
    logic signed [MW-1:0] mean;
    logic [VW-1:0]        var_s;
    logic [CW-1:0]        col;
    logic [ROW_W-1:0]     row;
    logic                 rlast;
    logic                 flast;
  } res_t;

  function automatic logic signed [MW-1:0] mterm(logic [SB-1:0] lo, logic [SB-1:0] hi,
                                                 logic one);
    logic signed [MW-1:0] d;
    d = MW'($signed(hi)) - MW'($signed(lo));
    return one ? (d <<< 1) : d;
  endfunction

  function automatic logic [VW-1:0] vterm(logic [SB-1:0] lo, logic [SB-1:0] hi, logic one);
    logic [VW-1:0] s;
    s = VW'(lo) + VW'(hi);
    return one ? (s << 2) : s;
  endfunction

  // ---------------------------------------------------------------- config
  logic [IMG_W_BITS-1:0] img_w_q;
  logic [IMG_H_BITS-1:0] img_h_q;
  logic                  cfg_hit;
  logic [CW-1:0]         wlast;
  logic [ROW_W-1:0]      hlast;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  cfg_hit = 1'b1;
        REG_IMAGE_HEIGHT: cfg_hit = 1'b1;
        default:          cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMG_W_RESET;
      img_h_q <= IMG_H_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: img_h_q <= cfg_data_i[IMG_H_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // effective width clamped to 2..MAX_WIDTH, height to 2..MAX_ROWS
  always_comb begin
    if (img_w_q < IMG_W_BITS'(2))       wlast = CW'(1);
    else if (32'(img_w_q) > MAX_WIDTH)  wlast = CW'(MAX_WIDTH - 1);
    else                                wlast = CW'(img_w_q - IMG_W_BITS'(1));

    if (img_h_q < IMG_H_BITS'(2))       hlast = ROW_W'(1);
    else if (32'(img_h_q) > MAX_ROWS)   hlast = ROW_W'(MAX_ROWS - 1);
    else                                hlast = ROW_W'(img_h_q - IMG_H_BITS'(1));
  end

  // ---------------------------------------------------------------- input side
  logic             primed_q;
  logic [CW-1:0]    col_q, col_d, nxt_col;
  logic [ROW_W-1:0] row_q, row_d;
  logic             in_acc;
  logic             s1_v_q, s1_adv;
  s1_t              s1_q;
  pix_t             cur;
  pix_t             in1_q, in2_q, prev_above_q;

  pix_t             ra_q;   // line buffer read data (row above)
  upair_t           rt_q;   // line buffer read data (two rows above, u only)
  logic             mem_re;
  logic [CW-1:0]    rd_addr;

  pix_t             above_mem [MAX_WIDTH];
  upair_t           two_mem   [MAX_WIDTH];

  assign cur           = s_axis_tdata[PW-1:0];
  assign s_axis_tready = primed_q && (!s1_v_q || s1_adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // read one column ahead: data arrives as the next pixel's "above" and as the
  // right neighbour of the pixel above this one
  assign nxt_col = (col_q == wlast) ? '0 : col_q + CW'(1);
  assign mem_re  = in_acc || !primed_q;
  assign rd_addr = primed_q ? nxt_col : '0;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (col_q == wlast) begin
        col_d = '0;
        row_d = (row_q == hlast) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = nxt_col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      primed_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      primed_q <= cfg_hit ? 1'b0 : 1'b1;
    end
  end

  // line buffers: write current column, prefetch next
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_mem[col_q] <= cur;
      two_mem[col_q]   <= '{vu: ra_q.vu, mu: ra_q.mu};
    end
    if (mem_re) begin
      ra_q <= above_mem[rd_addr];
      rt_q <= two_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in1_q        <= cur;
      in2_q        <= in1_q;
      prev_above_q <= ra_q;
      s1_q.cur     <= cur;
      s1_q.above   <= ra_q;
      s1_q.left    <= prev_above_q;
      s1_q.in1     <= in1_q;
      s1_q.in2     <= in2_q;
      s1_q.two     <= rt_q;
      s1_q.col     <= col_q;
      s1_q.row     <= row_q;
      s1_q.first   <= (col_q == '0);
      s1_q.last    <= (col_q == wlast);
      s1_q.col1    <= (col_q == CW'(1));
      s1_q.r0      <= (row_q == '0);
      s1_q.r1      <= (row_q == ROW_W'(1));
      s1_q.rlast   <= (row_q == hlast);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)         s1_v_q <= 1'b0;
    else if (in_acc)     s1_v_q <= 1'b1;
    else if (s1_adv)     s1_v_q <= 1'b0;
  end

  // ---------------------------------------------------------------- compute
  res_t       res_main, res_ba, res_bb;
  logic [1:0] n_res;
  pix_t       v_lo, v_hi;
  upair_t     u_lo;

  always_comb begin
    // main result: pixel one row up, same column
    u_lo = s1_q.r1 ? upair_t'{vu: s1_q.above.vu, mu: s1_q.above.mu} : s1_q.two;
    v_lo = s1_q.first ? s1_q.above : s1_q.left;
    v_hi = s1_q.last  ? s1_q.above : ra_q;
    res_main.mean  = mterm(u_lo.mu, s1_q.cur.mu, s1_q.r1)
                   + mterm(v_lo.mv, v_hi.mv, s1_q.first || s1_q.last);
    res_main.var_s = vterm(u_lo.vu, s1_q.cur.vu, s1_q.r1)
                   + vterm(v_lo.vv, v_hi.vv, s1_q.first || s1_q.last);
    res_main.col   = s1_q.col;
    res_main.row   = s1_q.row - ROW_W'(1);
    res_main.rlast = 1'b0;
    res_main.flast = 1'b0;

    // bottom row, previous column
    res_ba.mean  = mterm(s1_q.left.mu, s1_q.in1.mu, 1'b1)
                 + mterm(s1_q.col1 ? s1_q.in1.mv : s1_q.in2.mv, s1_q.cur.mv, s1_q.col1);
    res_ba.var_s = vterm(s1_q.left.vu, s1_q.in1.vu, 1'b1)
                 + vterm(s1_q.col1 ? s1_q.in1.vv : s1_q.in2.vv, s1_q.cur.vv, s1_q.col1);
    res_ba.col   = s1_q.col - CW'(1);
    res_ba.row   = s1_q.row;
    res_ba.rlast = 1'b0;
    res_ba.flast = 1'b0;

    // bottom row, last column (final pixel of the frame)
    res_bb.mean  = mterm(s1_q.above.mu, s1_q.cur.mu, 1'b1)
                 + mterm(s1_q.in1.mv, s1_q.cur.mv, 1'b1);
    res_bb.var_s = vterm(s1_q.above.vu, s1_q.cur.vu, 1'b1)
                 + vterm(s1_q.in1.vv, s1_q.cur.vv, 1'b1);
    res_bb.col   = s1_q.col;
    res_bb.row   = s1_q.row;
    res_bb.rlast = 1'b1;
    res_bb.flast = 1'b1;

    // results always come as main, then bottom-left, then bottom-last;
    // column 0 of the final row has no bottom column to its left
    if (s1_q.r0)                          n_res = 2'd0;
    else if (!s1_q.rlast || s1_q.first)   n_res = 2'd1;
    else if (s1_q.last)                   n_res = 2'd3;
    else                                  n_res = 2'd2;

    res_main.rlast = (n_res == 2'd1);
    res_ba.rlast   = (n_res == 2'd2);
  end

  // ---------------------------------------------------------------- output slots
  res_t       o_q [3];
  logic [1:0] cnt_q;
  logic       m_take, out_free, out_load;

  assign m_take   = m_axis_tvalid && m_axis_tready;
  assign out_free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_take);
  assign s1_adv   = s1_v_q && ((n_res == 2'd0) || out_free);
  assign out_load = s1_adv && (n_res != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          cnt_q <= 2'd0;
    else if (out_load)    cnt_q <= n_res;
    else if (m_take)      cnt_q <= cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_q[0] <= res_main;
      o_q[1] <= res_ba;
      o_q[2] <= res_bb;
    end else if (m_take) begin
      o_q[0] <= o_q[1];
      o_q[1] <= o_q[2];
    end
  end

  assign m_axis_tvalid   = (cnt_q != 2'd0);
  assign m_axis_tdata    = OUT_W'({o_q[0].row, o_q[0].col, o_q[0].var_s, o_q[0].mean});
  assign m_axis_tlast    = o_q[0].rlast;
  assign m_axis_tuser[0] = o_q[0].flast;

  // ---------------------------------------------------------------- checks
  logic head_at_end;

  assign head_at_end = (o_q[0].col == wlast) && (o_q[0].row == hlast);

`include "assert_macros.svh"

  `ASSERT_IMPL(a_flast_has_tlast, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
  `ASSERT_IMPL(a_flast_position, m_axis_tvalid && m_axis_tuser[0], head_at_end)
  `ASSERT_NEXT(a_cfg_reprimes, cfg_we_i && (cfg_idx_i == REG_IMAGE_WIDTH || cfg_idx_i == REG_IMAGE_HEIGHT), !s_axis_tready)

endmodule

`default_nettype wire
